[src/rfog_pkg.sv]
package rfog_pkg;

    // Default coordinate width
    localparam int COORD_BITS_DEF = 12;

    // Configuration port geometry
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;

    // Fixed-point constants
    localparam logic [16:0] LOG2E_Q16 = 17'd94548;
    localparam logic [15:0] ONE_Q15   = 16'd32768;
    localparam int          FRAC_STEPS = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CENTER_ROW  = 3'd0,
        REG_CENTER_COL  = 3'd1,
        REG_AIRLIGHT    = 3'd2,
        REG_DIST_GAIN   = 3'd3,
        REG_EXP_GAIN    = 3'd4,
        REG_EXP_OFFSET  = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [11:0]        center_row;
        logic [11:0]        center_col;
        logic [15:0]        airlight_level;
        logic [15:0]        distance_gain;
        logic [15:0]        exponent_gain;
        logic signed [15:0] exponent_offset;
    } cfg_t;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } rgb_t;

    // Q.16 values of 2^(-2^-(i+1))
    function automatic logic [15:0] pow2_frac(input logic [3:0] idx);
        logic [15:0] val;
        case (idx)
            4'd0:    val = 16'd46341;
            4'd1:    val = 16'd55109;
            4'd2:    val = 16'd60097;
            4'd3:    val = 16'd62757;
            4'd4:    val = 16'd64132;
            4'd5:    val = 16'd64830;
            4'd6:    val = 16'd65182;
            4'd7:    val = 16'd65359;
            4'd8:    val = 16'd65447;
            4'd9:    val = 16'd65492;
            4'd10:   val = 16'd65514;
            4'd11:   val = 16'd65525;
            4'd12:   val = 16'd65530;
            4'd13:   val = 16'd65533;
            default: val = 16'd65535;
        endcase
        return val;
    endfunction

endpackage

[src/rfog_in_if.sv]
interface rfog_in_if #(
    parameter int COORD_BITS = rfog_pkg::COORD_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pixel_row;
    logic [COORD_BITS-1:0] pixel_col;
    logic [7:0]            in_blue;
    logic [7:0]            in_green;
    logic [7:0]            in_red;

    modport source (
        output valid, pixel_row, pixel_col, in_blue, in_green, in_red,
        input  ready
    );

    modport sink (
        input  valid, pixel_row, pixel_col, in_blue, in_green, in_red,
        output ready
    );
endinterface

[src/rfog_out_if.sv]
interface rfog_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_blue;
    logic [7:0] out_green;
    logic [7:0] out_red;

    modport source (
        output valid, out_blue, out_green, out_red,
        input  ready
    );

    modport sink (
        input  valid, out_blue, out_green, out_red,
        output ready
    );
endinterface

[src/rfog_sqrt.sv]
module rfog_sqrt #(
    parameter int COORD_BITS = rfog_pkg::COORD_BITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    vld_i,
    input  logic [COORD_BITS-1:0]   row_i,
    input  logic [COORD_BITS-1:0]   col_i,
    input  logic [COORD_BITS-1:0]   crow_i,
    input  logic [COORD_BITS-1:0]   ccol_i,
    input  rfog_pkg::rgb_t          pix_i,
    output logic                    vld_o,
    output logic [COORD_BITS+8:0]   dist_o,
    output rfog_pkg::rgb_t          pix_o
);
    import rfog_pkg::*;

    localparam int D2W = 2 * COORD_BITS + 1;
    localparam int RW  = D2W + 17;
    localparam int NS  = RW / 2;
    localparam int RMW = NS + 2;

    // Squared distance stage
    logic signed [COORD_BITS:0]   dr, dc;
    logic [2*COORD_BITS+1:0]      sq_r, sq_c, sq_sum;
    logic [D2W-1:0]               d2_reg;
    rgb_t                         pix0_reg;
    logic                         vld0_reg;

    assign dr     = $signed({1'b0, row_i}) - $signed({1'b0, crow_i});
    assign dc     = $signed({1'b0, col_i}) - $signed({1'b0, ccol_i});
    assign sq_r   = dr * dr;
    assign sq_c   = dc * dc;
    assign sq_sum = sq_r + sq_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld0_reg <= 1'b0;
        end
        else if (en)
        begin
            vld0_reg <= vld_i;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d2_reg   <= sq_sum[D2W-1:0];
            pix0_reg <= pix_i;
        end
    end

    // One root digit per stage
    logic [RW-1:0]  rad_reg  [NS];
    logic [RMW-1:0] rem_reg  [NS];
    logic [NS-1:0]  root_reg [NS];
    rgb_t           pix_reg  [NS];
    logic [NS-1:0]  vld_reg;

    for (genvar g = 0; g < NS; g++)
    begin : g_step
        logic [RW-1:0]  rad_prev;
        logic [RMW-1:0] rem_prev;
        logic [NS-1:0]  root_prev;
        rgb_t           pix_prev;
        logic           vld_prev;
        logic [RMW-1:0] rem_sh, trial;
        logic [RMW-1:0] rem_next;
        logic [NS-1:0]  root_next;

        if (g == 0)
        begin : g_first
            assign rad_prev  = {1'b0, d2_reg, 16'd0};
            assign rem_prev  = '0;
            assign root_prev = '0;
            assign pix_prev  = pix0_reg;
            assign vld_prev  = vld0_reg;
        end
        else
        begin : g_rest
            assign rad_prev  = rad_reg[g-1];
            assign rem_prev  = rem_reg[g-1];
            assign root_prev = root_reg[g-1];
            assign pix_prev  = pix_reg[g-1];
            assign vld_prev  = vld_reg[g-1];
        end

        assign rem_sh = {rem_prev[RMW-3:0], rad_prev[RW-1 -: 2]};
        assign trial  = {root_prev, 2'b01};

        always_comb
        begin
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh - trial;
                root_next = {root_prev[NS-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {root_prev[NS-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[g] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[g] <= vld_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[g]  <= {rad_prev[RW-3:0], 2'b00};
                rem_reg[g]  <= rem_next;
                root_reg[g] <= root_next;
                pix_reg[g]  <= pix_prev;
            end
        end
    end

    assign vld_o  = vld_reg[NS-1];
    assign dist_o = root_reg[NS-1];
    assign pix_o  = pix_reg[NS-1];

endmodule

[src/rfog_trans.sv]
module rfog_trans #(
    parameter int COORD_BITS = rfog_pkg::COORD_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  rfog_pkg::cfg_t        cfg,
    input  logic                  vld_i,
    input  logic [COORD_BITS+8:0] dist_i,
    input  rfog_pkg::rgb_t        pix_i,
    output logic                  vld_o,
    output logic [15:0]           t_o,
    output rfog_pkg::rgb_t        pix_o
);
    import rfog_pkg::*;

    localparam int DW = COORD_BITS + 9;
    localparam int PW = DW + 16;
    localparam int SW = DW + 6;
    localparam int EW = SW + 17;

    // Stage 1: distance gain product
    logic [PW-1:0] p1_reg;
    rgb_t          pix1_reg;
    logic          vld1_reg;

    // Stage 2: add offset
    logic signed [SW-1:0] s2_reg;
    rgb_t                 pix2_reg;
    logic                 vld2_reg;
    logic signed [SW-1:0] s_next;

    // Stage 3: exponent gain product
    logic signed [EW-1:0] e3_reg;
    rgb_t                 pix3_reg;
    logic                 vld3_reg;

    // Stage 4: magnitude in Q.16 and clamp flags
    logic [19:0] m4_reg;
    logic        one4_reg, zero4_reg;
    rgb_t        pix4_reg;
    logic        vld4_reg;
    logic [EW-1:0] mag, m_full;

    // Stage 5: scale by log2(e)
    logic [20:0] y5_reg;
    logic        one5_reg, zero5_reg;
    rgb_t        pix5_reg;
    logic        vld5_reg;
    logic [36:0] y_prod;

    assign s_next = $signed({1'b0, p1_reg[PW-1:12]}) + SW'(cfg.exponent_offset);
    assign mag    = -e3_reg;
    assign m_full = (mag + EW'(15)) >> 4;
    assign y_prod = m4_reg * LOG2E_Q16;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
            vld4_reg <= 1'b0;
            vld5_reg <= 1'b0;
        end
        else if (en)
        begin
            vld1_reg <= vld_i;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
            vld4_reg <= vld3_reg;
            vld5_reg <= vld4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg    <= cfg.distance_gain * dist_i;
            pix1_reg  <= pix_i;
            s2_reg    <= s_next;
            pix2_reg  <= pix1_reg;
            e3_reg    <= $signed({1'b0, cfg.exponent_gain}) * s2_reg;
            pix3_reg  <= pix2_reg;
            one4_reg  <= ~e3_reg[EW-1];
            zero4_reg <= |m_full[EW-1:20];
            m4_reg    <= m_full[19:0];
            pix4_reg  <= pix3_reg;
            one5_reg  <= one4_reg;
            zero5_reg <= zero4_reg;
            y5_reg    <= y_prod[36:16];
            pix5_reg  <= pix4_reg;
        end
    end

    // Fraction bits: one table product per stage
    logic [16:0]         r_reg    [FRAC_STEPS];
    logic [20:0]         y_reg    [FRAC_STEPS];
    logic [1:0]          flag_reg [FRAC_STEPS];
    rgb_t                pix_reg  [FRAC_STEPS];
    logic [FRAC_STEPS-1:0] vld_reg;

    for (genvar g = 0; g < FRAC_STEPS; g++)
    begin : g_frac
        logic [16:0] r_prev;
        logic [20:0] y_prev;
        logic [1:0]  flag_prev;
        rgb_t        pix_prev;
        logic        vld_prev;
        logic [32:0] prod;

        if (g == 0)
        begin : g_first
            assign r_prev    = 17'h10000;
            assign y_prev    = y5_reg;
            assign flag_prev = {one5_reg, zero5_reg};
            assign pix_prev  = pix5_reg;
            assign vld_prev  = vld5_reg;
        end
        else
        begin : g_rest
            assign r_prev    = r_reg[g-1];
            assign y_prev    = y_reg[g-1];
            assign flag_prev = flag_reg[g-1];
            assign pix_prev  = pix_reg[g-1];
            assign vld_prev  = vld_reg[g-1];
        end

        assign prod = r_prev * pow2_frac(4'(g));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[g] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[g] <= vld_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[g]    <= y_prev[15-g] ? prod[32:16] : r_prev;
                y_reg[g]    <= y_prev;
                flag_reg[g] <= flag_prev;
                pix_reg[g]  <= pix_prev;
            end
        end
    end

    // Final stage: integer shift and clamps
    logic [4:0]  n_last;
    logic [16:0] r_sh;
    logic [15:0] t_next;
    logic [15:0] t_reg;
    rgb_t        pixt_reg;
    logic        vldt_reg;

    assign n_last = y_reg[FRAC_STEPS-1][20:16];
    assign r_sh   = r_reg[FRAC_STEPS-1] >> n_last[3:0];

    always_comb
    begin
        if (flag_reg[FRAC_STEPS-1][1])
        begin
            t_next = ONE_Q15;
        end
        else if (flag_reg[FRAC_STEPS-1][0] || n_last[4])
        begin
            t_next = '0;
        end
        else
        begin
            t_next = r_sh[16:1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vldt_reg <= 1'b0;
        end
        else if (en)
        begin
            vldt_reg <= vld_reg[FRAC_STEPS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg    <= t_next;
            pixt_reg <= pix_reg[FRAC_STEPS-1];
        end
    end

    assign vld_o = vldt_reg;
    assign t_o   = t_reg;
    assign pix_o = pixt_reg;

endmodule

[src/rfog_blend.sv]
module rfog_blend (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic [15:0]    airlight,
    input  logic           vld_i,
    input  logic [15:0]    t_i,
    input  rfog_pkg::rgb_t pix_i,
    output logic           vld_o,
    output rfog_pkg::rgb_t pix_o
);
    import rfog_pkg::*;

    // Stage 1: products
    logic [23:0] pb_reg, pg_reg, pr_reg;
    logic [31:0] fog_reg;
    logic        vld1_reg;
    logic [15:0] inv_t;

    assign inv_t = ONE_Q15 - t_i;

    // Stage 2: sum, scale and saturate
    logic [32:0] sb, sg, sr;
    rgb_t        out_next;
    rgb_t        out_reg;
    logic        vld2_reg;

    function automatic logic [7:0] sat8(input logic [32:0] sum);
        return (|sum[32:31]) ? 8'hFF : sum[30:23];
    endfunction

    assign sb = {1'b0, pb_reg, 8'd0} + {1'b0, fog_reg};
    assign sg = {1'b0, pg_reg, 8'd0} + {1'b0, fog_reg};
    assign sr = {1'b0, pr_reg, 8'd0} + {1'b0, fog_reg};

    always_comb
    begin
        out_next.blue  = sat8(sb);
        out_next.green = sat8(sg);
        out_next.red   = sat8(sr);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
        end
        else if (en)
        begin
            vld1_reg <= vld_i;
            vld2_reg <= vld1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pb_reg  <= pix_i.blue * t_i;
            pg_reg  <= pix_i.green * t_i;
            pr_reg  <= pix_i.red * t_i;
            fog_reg <= airlight * inv_t;
            out_reg <= out_next;
        end
    end

    assign vld_o = vld2_reg;
    assign pix_o = out_reg;

endmodule

[src/radial_fog_pixel_blend_top.sv]
// Radial fog blend: each pixel is mixed toward the fog light by a weight
// t = exp(exponent_gain*(distance_gain*d + exponent_offset)) clamped to [0,1],
// where d is the pixel's distance from the fog center. One item is accepted
// per clock while the output side takes results. The pipeline has one stage
// for the squared distance, COORD_BITS+9 stages of the digit-by-digit square
// root, 22 stages for the exponent (16 of them one per table product over
// the 16 fraction bits), and two for the blend. The whole pipeline holds
// when the output is stalled. Registers are written through cfg_we/cfg_index/
// cfg_data only while idle: a rule for the user, not enforced by the block.
module radial_fog_pixel_blend_top #(
    parameter int COORD_BITS = rfog_pkg::COORD_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    rfog_in_if.sink                            pix_in,
    rfog_out_if.source                         pix_out,
    input  logic                               cfg_we,
    input  logic [rfog_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rfog_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import rfog_pkg::*;

    localparam int DW = COORD_BITS + 9;

    // Configuration registers
    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.center_row      <= 12'd64;
            cfg_reg.center_col      <= 12'd128;
            cfg_reg.airlight_level  <= 16'd48960;
            cfg_reg.distance_gain   <= 16'd246;
            cfg_reg.exponent_gain   <= 16'd819;
            cfg_reg.exponent_offset <= -16'sd3840;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CENTER_ROW: cfg_reg.center_row      <= cfg_data[11:0];
                REG_CENTER_COL: cfg_reg.center_col      <= cfg_data[11:0];
                REG_AIRLIGHT:   cfg_reg.airlight_level  <= cfg_data;
                REG_DIST_GAIN:  cfg_reg.distance_gain   <= cfg_data;
                REG_EXP_GAIN:   cfg_reg.exponent_gain   <= cfg_data;
                REG_EXP_OFFSET: cfg_reg.exponent_offset <= $signed(cfg_data);
                default:        ;
            endcase
        end
    end

    // Global pipeline advance
    logic en;
    assign en           = !pix_out.valid || pix_out.ready;
    assign pix_in.ready = en;

    rgb_t                  pix_in_rgb, pix_sq, pix_tr, pix_res;
    logic                  vld_sq, vld_tr, vld_res;
    logic [DW-1:0]         dist_q8;
    logic [15:0]           t_val;
    logic [COORD_BITS-1:0] crow, ccol;

    assign pix_in_rgb.blue  = pix_in.in_blue;
    assign pix_in_rgb.green = pix_in.in_green;
    assign pix_in_rgb.red   = pix_in.in_red;
    assign crow = COORD_BITS'(cfg_reg.center_row);
    assign ccol = COORD_BITS'(cfg_reg.center_col);

    rfog_sqrt #(.COORD_BITS(COORD_BITS)) u_sqrt (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .vld_i  (pix_in.valid),
        .row_i  (pix_in.pixel_row),
        .col_i  (pix_in.pixel_col),
        .crow_i (crow),
        .ccol_i (ccol),
        .pix_i  (pix_in_rgb),
        .vld_o  (vld_sq),
        .dist_o (dist_q8),
        .pix_o  (pix_sq)
    );

    rfog_trans #(.COORD_BITS(COORD_BITS)) u_trans (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .cfg    (cfg_reg),
        .vld_i  (vld_sq),
        .dist_i (dist_q8),
        .pix_i  (pix_sq),
        .vld_o  (vld_tr),
        .t_o    (t_val),
        .pix_o  (pix_tr)
    );

    rfog_blend u_blend (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .airlight (cfg_reg.airlight_level),
        .vld_i    (vld_tr),
        .t_i      (t_val),
        .pix_i    (pix_tr),
        .vld_o    (vld_res),
        .pix_o    (pix_res)
    );

    assign pix_out.valid     = vld_res;
    assign pix_out.out_blue  = pix_res.blue;
    assign pix_out.out_green = pix_res.green;
    assign pix_out.out_red   = pix_res.red;

endmodule
